@@ rtl/usb_audio_rate_lock_tracker_unit_macros.svh @@
// assertion macros for the rate lock tracker
// no dependencies
`ifndef USB_AUDIO_RATE_LOCK_TRACKER_UNIT_MACROS_SVH
`define USB_AUDIO_RATE_LOCK_TRACKER_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define UART_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// implication whose consequent is checked at the next clock
`define UART_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/uarlt_pkg.sv @@
// shared constants, types and functions for the rate lock tracker
// no dependencies
package uarlt_pkg;
	localparam int RATE_TABLE_ENTRIES = 14;
	localparam int RIDX_W = $clog2(RATE_TABLE_ENTRIES);
	localparam logic [19:0] RATE_SAT = 20'hFFFFF;
	localparam logic [31:0] ACCUM_RESET = 32'd739875226;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	localparam logic [2:0] REG_RELOCK_GAP = 3'd0;
	localparam logic [2:0] REG_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_HOLDOFF = 3'd2;
	localparam logic [2:0] REG_MIN_PACKETS = 3'd3;
	localparam logic [2:0] REG_MIN_WINDOW = 3'd4;
	localparam logic [2:0] REG_FIFO_TARGET = 3'd5;
	localparam logic [2:0] REG_FB_SHIFT = 3'd6;

	// standard rates, ascending
	function automatic logic [18:0] rate_entry(input logic [RIDX_W-1:0] i);
		case (i)
			4'd0: rate_entry = 19'd8000;
			4'd1: rate_entry = 19'd11025;
			4'd2: rate_entry = 19'd12000;
			4'd3: rate_entry = 19'd16000;
			4'd4: rate_entry = 19'd22050;
			4'd5: rate_entry = 19'd24000;
			4'd6: rate_entry = 19'd32000;
			4'd7: rate_entry = 19'd44100;
			4'd8: rate_entry = 19'd48000;
			4'd9: rate_entry = 19'd88200;
			4'd10: rate_entry = 19'd96000;
			4'd11: rate_entry = 19'd176400;
			4'd12: rate_entry = 19'd192000;
			default: rate_entry = 19'd384000;
		endcase
	endfunction

	// divider control
	typedef struct packed {
		logic start;
		logic [51:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [51:0] quo;
	} div_rsp_t;
endpackage

@@ rtl/uarlt_divider.sv @@
// restoring divider, one quotient bit per cycle
// depends on uarlt_pkg
module uarlt_divider (
	input  logic clk,
	input  logic arst_n,
	input  uarlt_pkg::div_req_t req,
	output uarlt_pkg::div_rsp_t rsp
);
	import uarlt_pkg::*;

	logic [51:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [33:0] trial;

	// shifted remainder can reach 33 bits, so the borrow sits in bit 33
	assign trial = {1'b0, rem_q[31:0], quo_q[51]} - {2'b00, den_q};

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd52;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[50:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[51]};
				quo_q <= {quo_q[50:0], 1'b0};
			end
		end
	end

	assign rsp.done = busy_q && (cnt_q == 6'd1);
	assign rsp.quo = (!trial[33]) ? {quo_q[50:0], 1'b1} : {quo_q[50:0], 1'b0};
endmodule

@@ rtl/usb_audio_rate_lock_tracker_unit.sv @@
// rate lock tracker top level: control sequencer, state, snap scan
// depends on uarlt_pkg, uarlt_divider and the assertion macros
// the result is valid in the cycle after accept when no rate is computed; a rate computation
// adds a multiply state, the serial divide and a table scan before the result
// the serial divider (one quotient bit a cycle) sets the rate; one item at a time
// reset: asynchronous active low; registers return to defaults, rate 44100, no lock
`include "usb_audio_rate_lock_tracker_unit_macros.svh"
module usb_audio_rate_lock_tracker_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic action,
	input  logic [31:0] now_us,
	input  logic [7:0] frame_count,
	input  logic stream_active,
	input  logic [7:0] fifo_fill,
	output logic out_valid,
	input  logic out_ready,
	output logic [19:0] meas_rate,
	output logic [18:0] standard_rate,
	output logic rate_locked,
	output logic lock_pending,
	output logic rate_stable,
	output logic holdoff_active,
	output logic [31:0] feedback_word,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import uarlt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_SNAP = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [23:0] relock_gap_q, timeout_q, holdoff_cfg_q;
	logic [7:0] min_packets_q, fifo_target_q;
	logic [19:0] min_window_q;
	logic [4:0] fb_shift_q;

	logic prev_active_q, pending_q, locked_q, relock_q, seen_q, last_valid_q, armed_q;
	logic [15:0] packets_q;
	logic [31:0] window_start_q, frames_q, last_time_q, holdoff_until_q;
	logic [19:0] rate_meas_q;
	logic [18:0] rate_std_q;
	logic [31:0] accum_q;
	logic [31:0] now_q, elapsed_q;
	logic active_q;
	logic [RIDX_W-1:0] idx_q;

	div_req_t dreq;
	div_rsp_t drsp;

	uarlt_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// next-state logic for one item, computed combinationally at accept
	logic n_prev, n_pend, n_lock, n_rel, n_seen, n_lv, n_arm, n_div;
	logic [15:0] n_pk;
	logic [31:0] n_ws, n_fr, n_lt, n_hu, n_acc, n_el, d, gap, sum;
	logic [32:0] fsum;
	always_comb begin
		n_prev = prev_active_q; n_pend = pending_q; n_lock = locked_q; n_rel = relock_q;
		n_seen = seen_q; n_lv = last_valid_q; n_arm = armed_q; n_pk = packets_q;
		n_ws = window_start_q; n_fr = frames_q; n_lt = last_time_q; n_hu = holdoff_until_q;
		n_acc = accum_q; n_div = 1'b0; n_el = now_us - window_start_q;
		d = '0; fsum = '0; sum = '0;
		gap = now_us - last_time_q;
		if (!action) begin
			n_seen = 1'b1;
			if (stream_active) begin
				if (last_valid_q && gap > {8'd0, relock_gap_q}) begin
					n_rel = 1'b1; n_lock = 1'b0;
				end
				if (!pending_q && !n_lock) begin
					n_pend = 1'b1; n_lock = 1'b0; n_pk = '0; n_fr = '0; n_ws = now_us;
					n_lt = now_us; n_lv = 1'b1; n_hu = now_us + {8'd0, holdoff_cfg_q};
					n_arm = 1'b1;
				end
				if (n_pend) begin
					if (!n_lv || (now_us - n_lt) > {8'd0, timeout_q}) begin
						n_lock = 1'b0; n_pk = '0; n_fr = '0; n_ws = now_us;
						n_hu = now_us + {8'd0, holdoff_cfg_q}; n_arm = 1'b1;
					end
					if (n_pk != 16'hFFFF) n_pk = n_pk + 16'd1;
					fsum = {1'b0, n_fr} + {25'd0, frame_count};
					n_fr = fsum[32] ? 32'hFFFFFFFF : fsum[31:0];
					n_el = now_us - n_ws;
					if (!(n_pk < {8'd0, min_packets_q} || n_el < {12'd0, min_window_q}
						|| n_el == '0))
						n_div = 1'b1;
				end
			end
			n_lt = now_us; n_lv = 1'b1;
		end else begin
			if (stream_active != prev_active_q) begin
				n_prev = stream_active; n_seen = 1'b0;
				if (!stream_active) begin
					n_pend = 1'b0; n_lock = 1'b0; n_rel = 1'b0; n_pk = '0; n_ws = '0;
					n_fr = '0; n_lt = '0; n_lv = 1'b0;
				end else begin
					n_pend = 1'b1; n_lock = 1'b0; n_pk = '0; n_fr = '0; n_ws = now_us;
					n_lt = now_us; n_lv = 1'b1; n_hu = now_us + {8'd0, holdoff_cfg_q};
					n_arm = 1'b1;
				end
			end
			if (n_rel && stream_active) begin
				n_rel = 1'b0; n_seen = 1'b0;
				n_pend = 1'b1; n_lock = 1'b0; n_pk = '0; n_fr = '0; n_ws = now_us;
				n_lt = now_us; n_lv = 1'b1; n_hu = now_us + {8'd0, holdoff_cfg_q};
				n_arm = 1'b1;
			end
			d = n_hu - now_us;
			sum = accum_q + {24'd0, fifo_target_q} - {24'd0, fifo_fill};
			if (n_seen && !(n_arm && d != '0 && !d[31])) n_acc = sum;
			n_seen = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relock_gap_q <= 24'd20000; timeout_q <= 24'd1000000;
			holdoff_cfg_q <= 24'd1000000; min_packets_q <= 8'd8;
			min_window_q <= 20'd3000; fifo_target_q <= 8'd8; fb_shift_q <= 5'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RELOCK_GAP: relock_gap_q <= cfg_data[23:0];
				REG_TIMEOUT: timeout_q <= cfg_data[23:0];
				REG_HOLDOFF: holdoff_cfg_q <= cfg_data[23:0];
				REG_MIN_PACKETS: min_packets_q <= cfg_data[7:0];
				REG_MIN_WINDOW: min_window_q <= cfg_data[19:0];
				REG_FIFO_TARGET: fifo_target_q <= cfg_data[7:0];
				REG_FB_SHIFT: fb_shift_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// snap scan compare against current entry
	logic [19:0] ent, prv;
	logic [20:0] dlo, dhi;
	assign ent = {1'b0, rate_entry(idx_q)};
	assign prv = {1'b0, rate_entry(idx_q - RIDX_W'(1))};
	assign dlo = {1'b0, rate_meas_q} - {1'b0, prv};
	assign dhi = {1'b0, ent} - {1'b0, rate_meas_q};

	// product formed from the registered frame total in the multiply cycle
	assign dreq.start = (state_q == ST_MUL);
	assign dreq.num = {20'd0, frames_q} * {32'd0, US_PER_S};
	assign dreq.den = elapsed_q;

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_active_q <= 1'b0; pending_q <= 1'b0; locked_q <= 1'b0; relock_q <= 1'b0;
			seen_q <= 1'b0; last_valid_q <= 1'b0; armed_q <= 1'b0;
			packets_q <= '0; window_start_q <= '0; frames_q <= '0; last_time_q <= '0;
			holdoff_until_q <= '0; rate_meas_q <= 20'd44100; rate_std_q <= 19'd44100;
			accum_q <= ACCUM_RESET; idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					prev_active_q <= n_prev; pending_q <= n_pend; locked_q <= n_lock;
					relock_q <= n_rel; seen_q <= n_seen; last_valid_q <= n_lv;
					armed_q <= n_arm; packets_q <= n_pk; window_start_q <= n_ws;
					frames_q <= n_fr; last_time_q <= n_lt; holdoff_until_q <= n_hu;
					accum_q <= n_acc;
					state_q <= n_div ? ST_MUL : ST_OUT;
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: if (drsp.done) begin
					rate_meas_q <= (drsp.quo > 52'(RATE_SAT)) ? RATE_SAT : drsp.quo[19:0];
					idx_q <= RIDX_W'(1);
					state_q <= ST_SNAP;
				end
				ST_SNAP: begin
					if (rate_meas_q <= {1'b0, rate_entry('0)}) begin
						rate_std_q <= rate_entry('0);
						pending_q <= 1'b0; locked_q <= 1'b1; state_q <= ST_OUT;
					end else if (ent >= rate_meas_q) begin
						rate_std_q <= (dlo < dhi) ? prv[18:0] : ent[18:0];
						pending_q <= 1'b0; locked_q <= 1'b1; state_q <= ST_OUT;
					end else if (idx_q == RIDX_W'(RATE_TABLE_ENTRIES - 1)) begin
						rate_std_q <= rate_entry(RIDX_W'(RATE_TABLE_ENTRIES - 1));
						pending_q <= 1'b0; locked_q <= 1'b1; state_q <= ST_OUT;
					end else idx_q <= idx_q + RIDX_W'(1);
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction snapshot
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			now_q <= now_us; active_q <= stream_active; elapsed_q <= n_el;
		end
	end

	logic [31:0] od, hd;
	assign od = now_q - last_time_q;
	assign hd = holdoff_until_q - now_q;
	assign meas_rate = rate_meas_q;
	assign standard_rate = rate_std_q;
	assign rate_locked = locked_q;
	assign lock_pending = pending_q;
	assign rate_stable = active_q && locked_q && last_valid_q && (od < {8'd0, timeout_q});
	assign holdoff_active = armed_q && hd != '0 && !hd[31];
	assign feedback_word = accum_q >> fb_shift_q;

	`UART_ASSERT_IMP(a_lock_excl, clk, arst_n, out_valid, !(rate_locked && lock_pending),
		"locked and pending together")
	`UART_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result dropped before taken")
	`UART_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid,
		"ready while result held")
	`UART_ASSERT_IMP(a_std_range, clk, arst_n, out_valid,
		standard_rate >= 19'd8000 && standard_rate <= 19'd384000,
		"standard rate out of range")
endmodule

@@ sim/tb_usb_audio_rate_lock_tracker_unit.sv @@
// testbench for usb_audio_rate_lock_tracker_unit: directed and random packet/poll traffic
// depends on uarlt_pkg and the rate lock tracker rtl; own predictor held in a scoreboard class
`timescale 1ns / 1ps

typedef struct packed {
	logic [19:0] meas_rate;
	logic [18:0] standard_rate;
	logic rate_locked;
	logic lock_pending;
	logic rate_stable;
	logic holdoff_active;
	logic [31:0] feedback_word;
} tracker_status_t;

class rate_lock_scoreboard;
	// register copies
	bit [31:0] relock_gap, timeout, holdoff, min_pkts, min_win, target, fb_shift;
	// tracker state
	bit was_active, pending, locked, relock_req, seen_pkt, have_time, hold_armed;
	bit [31:0] pkt_count, win_start, frame_sum, last_time, hold_until;
	bit [31:0] rate_meas, rate_std, accum;
	tracker_status_t status_q[$];
	int errors;

	function new();
		relock_gap = 20000; timeout = 1000000; holdoff = 1000000;
		min_pkts = 8; min_win = 3000; target = 8; fb_shift = 10;
		was_active = 0; pending = 0; locked = 0; relock_req = 0; seen_pkt = 0;
		have_time = 0; hold_armed = 0;
		pkt_count = 0; win_start = 0; frame_sum = 0; last_time = 0; hold_until = 0;
		rate_meas = 44100; rate_std = 44100; accum = uarlt_pkg::ACCUM_RESET;
		errors = 0;
	endfunction

	function void write_reg(bit [2:0] idx, bit [31:0] val);
		case (idx)
			uarlt_pkg::REG_RELOCK_GAP: relock_gap = val & 32'hFFFFFF;
			uarlt_pkg::REG_TIMEOUT: timeout = val & 32'hFFFFFF;
			uarlt_pkg::REG_HOLDOFF: holdoff = val & 32'hFFFFFF;
			uarlt_pkg::REG_MIN_PACKETS: min_pkts = val & 32'hFF;
			uarlt_pkg::REG_MIN_WINDOW: min_win = val & 32'hFFFFF;
			uarlt_pkg::REG_FIFO_TARGET: target = val & 32'hFF;
			uarlt_pkg::REG_FB_SHIFT: fb_shift = val & 32'h1F;
			default: ;
		endcase
	endfunction

	// nearest standard rate, ties go up
	function bit [31:0] nearest_rate(bit [31:0] m);
		bit [31:0] rates [14];
		rates = '{8000, 11025, 12000, 16000, 22050, 24000, 32000,
			44100, 48000, 88200, 96000, 176400, 192000, 384000};
		if (m <= rates[0]) return rates[0];
		for (int i = 1; i < 14; i++)
			if (rates[i] >= m)
				return ((m - rates[i-1]) < (rates[i] - m)) ? rates[i-1] : rates[i];
		return rates[13];
	endfunction

	function void start_window(bit [31:0] t);
		pending = 1; locked = 0; pkt_count = 0; frame_sum = 0;
		win_start = t; last_time = t; have_time = 1;
		hold_until = t + holdoff; hold_armed = 1;
	endfunction

	function bit in_holdoff(bit [31:0] t);
		bit [31:0] d;
		d = hold_until - t;
		return hold_armed && d != 0 && !d[31];
	endfunction

	function void measure(bit [31:0] frames, bit [31:0] t);
		bit [31:0] span;
		bit [63:0] r;
		if (!pending) return;
		if (!have_time || (t - last_time) > timeout) start_window(t);
		last_time = t; have_time = 1;
		if (pkt_count < 32'hFFFF) pkt_count++;
		frame_sum = (frame_sum > 32'hFFFFFFFF - frames) ? 32'hFFFFFFFF : frame_sum + frames;
		span = t - win_start;
		if (pkt_count < min_pkts || span < min_win || span == 0) return;
		r = (64'(frame_sum) * 64'd1000000) / span;
		if (r > 64'hFFFFF) r = 64'hFFFFF;
		rate_meas = r[31:0];
		rate_std = nearest_rate(rate_meas);
		pending = 0; locked = 1;
	endfunction

	// note an accepted item and queue its status
	function void note_item(bit poll, bit [31:0] t, bit [7:0] frames, bit active,
		bit [7:0] level);
		tracker_status_t s;
		bit seen;
		if (!poll) begin
			seen_pkt = 1;
			if (active) begin
				if (have_time && (t - last_time) > relock_gap) begin
					relock_req = 1; locked = 0;
				end
				if (!pending && !locked) start_window(t);
				measure(32'(frames), t);
			end
			last_time = t; have_time = 1;
		end else begin
			if (active != was_active) begin
				was_active = active; seen_pkt = 0;
				if (!active) begin
					pending = 0; locked = 0; relock_req = 0; pkt_count = 0;
					win_start = 0; frame_sum = 0; last_time = 0; have_time = 0;
				end else begin
					start_window(t);
				end
			end
			if (relock_req && active) begin
				relock_req = 0; seen_pkt = 0; start_window(t);
			end
			seen = seen_pkt; seen_pkt = 0;
			if (seen && !in_holdoff(t)) accum = accum + target - 32'(level);
		end
		s.meas_rate = rate_meas[19:0];
		s.standard_rate = rate_std[18:0];
		s.rate_locked = locked;
		s.lock_pending = pending;
		s.rate_stable = active && locked && have_time && ((t - last_time) < timeout);
		s.holdoff_active = in_holdoff(t);
		s.feedback_word = accum >> fb_shift[4:0];
		status_q.push_back(s);
	endfunction

	function void check_status(tracker_status_t got);
		tracker_status_t e;
		if (status_q.size() == 0) begin
			$error("unexpected result transaction");
			errors++;
			return;
		end
		e = status_q.pop_front();
		if (e.meas_rate !== got.meas_rate) begin
			$error("meas_rate exp %0d got %0d", e.meas_rate, got.meas_rate); errors++;
		end
		if (e.standard_rate !== got.standard_rate) begin
			$error("standard_rate exp %0d got %0d", e.standard_rate, got.standard_rate); errors++;
		end
		if (e.rate_locked !== got.rate_locked) begin
			$error("rate_locked exp %0d got %0d", e.rate_locked, got.rate_locked); errors++;
		end
		if (e.lock_pending !== got.lock_pending) begin
			$error("lock_pending exp %0d got %0d", e.lock_pending, got.lock_pending); errors++;
		end
		if (e.rate_stable !== got.rate_stable) begin
			$error("rate_stable exp %0d got %0d", e.rate_stable, got.rate_stable); errors++;
		end
		if (e.holdoff_active !== got.holdoff_active) begin
			$error("holdoff_active exp %0d got %0d", e.holdoff_active, got.holdoff_active);
			errors++;
		end
		if (e.feedback_word !== got.feedback_word) begin
			$error("feedback_word exp %0h got %0h", e.feedback_word, got.feedback_word); errors++;
		end
	endfunction
endclass

module tb_usb_audio_rate_lock_tracker_unit;
	import uarlt_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, action = 0, stream_active = 0;
	logic [31:0] now_us = 0;
	logic [7:0] frame_count = 0, fifo_fill = 0;
	logic in_ready, out_valid, out_ready = 0;
	logic [19:0] meas_rate;
	logic [18:0] standard_rate;
	logic rate_locked, lock_pending, rate_stable, holdoff_active;
	logic [31:0] feedback_word;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	rate_lock_scoreboard sb = new();
	int cycle_count = 0;
	bit calm = 0;
	bit [31:0] clock_us = 0;
	bit active_now = 0;

	usb_audio_rate_lock_tracker_unit i_dut (.*);

	always #1 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("usb_audio_rate_lock_tracker_unit regression: fail");
			$finish;
		end
	end

	// result side: random stalls, check on each transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status({meas_rate, standard_rate, rate_locked, lock_pending,
				rate_stable, holdoff_active, feedback_word});
		out_ready <= calm || ($urandom_range(99) >= 33);
	end

	// each transaction first waits for a clock edge so valid is never assigned twice in a step
	task automatic write_reg(bit [2:0] idx, bit [31:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (sb.status_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_item(bit poll, bit [31:0] t, bit [7:0] frames, bit active,
		bit [7:0] level);
		@(posedge clk);
		if (!calm) while ($urandom_range(99) < 33) @(posedge clk);
		in_valid <= 1; action <= poll; now_us <= t; frame_count <= frames;
		stream_active <= active; fifo_fill <= level;
		do @(posedge clk); while (!in_ready);
		sb.note_item(poll, t, frames, active, level);
		in_valid <= 0;
	endtask

	// one stream: enable poll, packets mostly about 1 ms apart with occasional gaps, random polls
	task automatic stream_burst(int n);
		bit [7:0] fr;
		fr = 8'($urandom_range(8, 200));
		active_now = 1;
		send_item(1, clock_us, 0, 1, 8'($urandom));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: clock_us += $urandom_range(20000, 60000);
				1: clock_us += $urandom;
				default: clock_us += $urandom_range(900, 1100);
			endcase
			if ($urandom_range(4) == 0)
				send_item(1, clock_us, 8'($urandom), active_now, 8'($urandom));
			else if ($urandom_range(29) == 0)
				send_item(0, clock_us, fr, 0, 8'($urandom));
			else
				send_item(0, clock_us, ($urandom_range(3) == 0) ? 8'($urandom) : fr,
					1, 8'($urandom));
		end
		if ($urandom_range(1)) begin
			active_now = 0;
			send_item(1, clock_us, 0, 0, 8'($urandom));
		end
	endtask

	initial begin
		int sent;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// small windows so directed locks come quickly
		write_reg(REG_MIN_PACKETS, 1);
		write_reg(REG_MIN_WINDOW, 1);
		write_reg(REG_HOLDOFF, 0);
		// directed: poll enable, locks on high rates, relocks after long gaps, a timestamp wrap, disable
		send_item(1, 32'd100, 0, 1, 8'd0);
		send_item(0, 32'd100, 8'd255, 1, 8'd0);
		send_item(0, 32'd1100, 8'd1, 1, 8'd255);
		send_item(1, 32'd1200, 8'd255, 1, 8'd255);
		send_item(0, 32'd1201, 8'd255, 0, 8'd0);
		send_item(1, 32'd1300, 0, 1, 8'd0);
		send_item(0, 32'd30000, 8'd48, 1, 8'd7);
		send_item(1, 32'd30001, 0, 1, 8'd3);
		send_item(0, 32'd30001, 8'd255, 1, 8'd0);
		send_item(0, 32'd31001, 8'd96, 1, 8'd0);
		send_item(0, 32'hFFFF_FFF0, 8'd44, 1, 8'd0);
		send_item(1, 32'hFFFF_FFFF, 0, 1, 8'd255);
		send_item(0, 32'd2000, 8'd255, 1, 8'd0);
		send_item(1, 32'd2001, 0, 0, 8'd128);
		send_item(0, 32'd2002, 8'd10, 0, 8'd0);
		send_item(1, 32'd2003, 0, 0, 8'd0);
		drain();

		// settings sweep: defaults, extremes, then random
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_RELOCK_GAP, 20000); write_reg(REG_TIMEOUT, 1000000);
					write_reg(REG_HOLDOFF, 1000000); write_reg(REG_MIN_PACKETS, 8);
					write_reg(REG_MIN_WINDOW, 3000); write_reg(REG_FIFO_TARGET, 8);
					write_reg(REG_FB_SHIFT, 10);
				end
				1: begin
					write_reg(REG_RELOCK_GAP, 0); write_reg(REG_TIMEOUT, 0);
					write_reg(REG_HOLDOFF, 0); write_reg(REG_MIN_PACKETS, 1);
					write_reg(REG_MIN_WINDOW, 1); write_reg(REG_FIFO_TARGET, 0);
					write_reg(REG_FB_SHIFT, 0);
				end
				2: begin
					write_reg(REG_RELOCK_GAP, 24'hFFFFFF); write_reg(REG_TIMEOUT, 24'hFFFFFF);
					write_reg(REG_HOLDOFF, 24'hFFFFFF); write_reg(REG_MIN_PACKETS, 255);
					write_reg(REG_MIN_WINDOW, 20'hFFFFF); write_reg(REG_FIFO_TARGET, 255);
					write_reg(REG_FB_SHIFT, 31);
				end
				default: begin
					write_reg(REG_RELOCK_GAP, $urandom_range(500, 40000));
					write_reg(REG_TIMEOUT, $urandom_range(1000, 24'hFFFFFF));
					write_reg(REG_HOLDOFF, $urandom_range(0, 50000));
					write_reg(REG_MIN_PACKETS, $urandom_range(1, 16));
					write_reg(REG_MIN_WINDOW, $urandom_range(1, 8000));
					write_reg(REG_FIFO_TARGET, $urandom_range(255));
					write_reg(REG_FB_SHIFT, $urandom_range(31));
				end
			endcase
			calm = (phase == 3);
			sent = 0;
			while (sent < 160) begin
				stream_burst(25);
				sent += 27;
				// noise items
				send_item(1'($urandom), $urandom, 8'($urandom), 1'($urandom), 8'($urandom));
				if (sent > 80 && sent < 110) begin
					// sender holds off until all results are back
					while (sb.status_q.size() != 0) @(posedge clk);
				end
			end
			calm = 0;
			drain();
		end

		if (sb.errors == 0 && sb.status_q.size() == 0)
			$display("usb_audio_rate_lock_tracker_unit regression: pass");
		else
			$display("usb_audio_rate_lock_tracker_unit regression: fail");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/uarlt_pkg.sv
rtl/uarlt_divider.sv
rtl/usb_audio_rate_lock_tracker_unit.sv
sim/tb_usb_audio_rate_lock_tracker_unit.sv
